// ===== hw/rtl/tccw_pkg.sv =====
// tccw_pkg: shared constants, command codes and link types for the text
// console character writer. No dependencies.

package tccw_pkg;

    // Grid geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;

    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ADDR_W = $clog2(CELL_COUNT);

    // Command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    localparam logic [7:0] BLANK_CHAR = 8'h20;
    localparam logic [7:0] RESET_ATTR = 8'h0F;
    localparam int         TAB_STEP   = 8;

    // Input modes
    localparam logic [1:0] MODE_PUT   = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // Control characters
    localparam logic [7:0] CH_BS  = 8'd8;
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_CR  = 8'd13;

    // Command kinds produced by the front
    localparam logic [2:0] K_CHAR      = 3'd0;
    localparam logic [2:0] K_NEWLINE   = 3'd1;
    localparam logic [2:0] K_RETURN    = 3'd2;
    localparam logic [2:0] K_TAB       = 3'd3;
    localparam logic [2:0] K_BACKSPACE = 3'd4;
    localparam logic [2:0] K_CLEAR     = 3'd5;
    localparam logic [2:0] K_READ      = 3'd6;
    localparam logic [2:0] K_NONE      = 3'd7;

    typedef struct packed {
        logic [2:0]        kind;
        logic [7:0]        char_code;
        logic [ADDR_W-1:0] cell_addr;
        logic              read_ok;
    } t_cmd;

    // Queue head as seen by the back end
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_out;

    // Back end to front end
    typedef struct packed {
        logic pop;
        logic init_busy;
    } t_back_ctrl;

endpackage

// ===== hw/rtl/text_console_char_writer_unit.sv =====
// text_console_char_writer_unit: top level of the text console engine.
// Depends on tccw_pkg, tccw_front and tccw_back.
//
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_stall    i_mode, i_char_code, i_cell_index
//  output    out        o_out_valid / i_out_stall  o_cursor_line, o_cursor_column,
//                                                  o_cursor_position, o_scrolled,
//                                                  o_cell_data
//  config    in         i_cfg_we                   i_cfg_wdata (text attribute)
//
// Printing characters, control characters and unused modes go from S_IDLE to
// S_EMIT in the back end, reads through S_READ (registered memory port) first;
// one result each. A scroll blanks COLUMNS cells and a clear CELL_COUNT cells
// in S_FILL: one cell is blanked per cycle through the single memory write port.
// After reset a blanking pass over all CELL_COUNT cells runs with o_in_stall high.
// A two-entry command queue keeps the input side moving while the back end
// works or the output is stalled; the result register holds until taken.

module text_console_char_writer_unit
    import tccw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_char_code,
    input  logic [10:0] i_cell_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [4:0]  o_cursor_line,
    output logic [6:0]  o_cursor_column,
    output logic [10:0] o_cursor_position,
    output logic        o_scrolled,
    output logic [15:0] o_cell_data
);

    t_q_out     q_link;
    t_back_ctrl back_ctrl;

    tccw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .i_ctrl       (back_ctrl),
        .o_q          (q_link)
    );

    tccw_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_q               (q_link),
        .o_ctrl            (back_ctrl),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_cursor_line     (o_cursor_line),
        .o_cursor_column   (o_cursor_column),
        .o_cursor_position (o_cursor_position),
        .o_scrolled        (o_scrolled),
        .o_cell_data       (o_cell_data)
    );

endmodule

// ===== hw/rtl/tccw_front.sv =====
// tccw_front: accepts input transactions, classifies them into commands and
// holds them in a short queue for the back end. Depends on tccw_pkg.

module tccw_front
    import tccw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_char_code,
    input  logic [10:0] i_cell_index,
    input  t_back_ctrl i_ctrl,
    output t_q_out     o_q
);

    t_cmd                cmd_in;
    t_cmd                r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr;
    logic [Q_PTR_W:0]    r_count;
    logic [Q_PTR_W:0]    n_count;
    logic                push;
    logic                full;

    always_comb begin
        cmd_in.char_code = i_char_code;
        cmd_in.cell_addr = ADDR_W'(i_cell_index);
        cmd_in.read_ok   = (32'(i_cell_index) < CELL_COUNT);
        unique case (i_mode)
            MODE_PUT: begin
                unique case (i_char_code)
                    CH_LF:   cmd_in.kind = K_NEWLINE;
                    CH_CR:   cmd_in.kind = K_RETURN;
                    CH_TAB:  cmd_in.kind = K_TAB;
                    CH_BS:   cmd_in.kind = K_BACKSPACE;
                    default: cmd_in.kind = K_CHAR;
                endcase
            end
            MODE_CLEAR: cmd_in.kind = K_CLEAR;
            MODE_READ:  cmd_in.kind = K_READ;
            default:    cmd_in.kind = K_NONE;
        endcase
    end

    assign full       = (r_count == (Q_PTR_W+1)'(Q_DEPTH));
    // Nothing is taken while the reset pass is still blanking the grid
    assign o_in_stall = full || i_ctrl.init_busy;
    assign push       = i_in_valid && !o_in_stall;

    always_comb begin
        case ({push, i_ctrl.pop})
            2'b10:   n_count = r_count + (Q_PTR_W+1)'(1);
            2'b01:   n_count = r_count - (Q_PTR_W+1)'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_ctrl.pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

    assign o_q.valid = (r_count != '0);
    assign o_q.cmd   = r_q[r_rd_ptr];

`ifndef SYNTHESIS
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.pop |-> (r_count != '0))
        else $error("queue popped while empty");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (Q_PTR_W+1)'(Q_DEPTH))
        else $error("queue count beyond depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !full)
        else $error("transaction taken into a full queue");
`endif

endmodule

// ===== hw/rtl/tccw_back.sv =====
// tccw_back: executes queued commands against the cell memory and cursor,
// handles fills and scrolls, and owns the result register. Depends on tccw_pkg.

module tccw_back
    import tccw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  t_q_out      i_q,
    output t_back_ctrl  o_ctrl,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [4:0]  o_cursor_line,
    output logic [6:0]  o_cursor_column,
    output logic [10:0] o_cursor_position,
    output logic        o_scrolled,
    output logic [15:0] o_cell_data
);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_FILL = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    localparam logic [ADDR_W:0]   CELLS_X    = (ADDR_W+1)'(CELL_COUNT);
    localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] BOTTOM_LIN = ADDR_W'((ROWS - 1) * COLUMNS);
    localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
    localparam logic [COL_W:0]    COLS_C     = (COL_W+1)'(COLUMNS);
    localparam logic [COL_W:0]    TAB_MASK   = ~((COL_W+1)'(TAB_STEP - 1));

    // Rows are kept circularly: r_base is the physical address of logical row 0
    function automatic logic [ADDR_W-1:0] f_phys(input logic [ADDR_W-1:0] lin,
                                                 input logic [ADDR_W-1:0] base);
        logic [ADDR_W:0] s;
        s = {1'b0, lin} + {1'b0, base};
        if (s >= CELLS_X) begin
            s = s - CELLS_X;
        end
        return s[ADDR_W-1:0];
    endfunction

    logic [15:0]       r_mem [CELL_COUNT];
    logic [15:0]       r_rd_data;

    logic [2:0]        r_state,     n_state;
    logic [ROW_W-1:0]  r_row,       n_row;
    logic [COL_W-1:0]  r_col,       n_col;
    logic [ADDR_W-1:0] r_lin,       n_lin;
    logic [ADDR_W-1:0] r_base,      n_base;
    logic [7:0]        r_attr;
    logic [ADDR_W-1:0] r_fill_addr, n_fill_addr;
    logic [ADDR_W-1:0] r_fill_end,  n_fill_end;
    logic              r_pend_scr,  n_pend_scr;
    logic [15:0]       r_pend_data, n_pend_data;
    logic              r_rd_ok,     n_rd_ok;

    logic              r_out_valid;
    logic [4:0]        r_out_row;
    logic [6:0]        r_out_col;
    logic [10:0]       r_out_pos;
    logic              r_out_scr;
    logic [15:0]       r_out_data;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [15:0]       wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              pop;
    logic              load_out;
    logic              adv_row;
    logic              out_free;

    logic [ADDR_W-1:0] row_start;
    logic [ADDR_W-1:0] bs_lin;
    logic [COL_W:0]    col_inc;
    logic [COL_W:0]    tab_col;
    logic [31:0]       row_ext;
    logic [31:0]       col_ext;
    logic [31:0]       lin_ext;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign row_start = r_lin - ADDR_W'(r_col);
    assign bs_lin    = (r_col != '0) ? (r_lin - ADDR_W'(1)) : r_lin;
    assign col_inc   = {1'b0, r_col} + (COL_W+1)'(1);
    assign tab_col   = ({1'b0, r_col} + (COL_W+1)'(TAB_STEP)) & TAB_MASK;
    assign row_ext   = 32'(r_row);
    assign col_ext   = 32'(r_col);
    assign lin_ext   = 32'(r_lin);

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_lin       = r_lin;
        n_base      = r_base;
        n_fill_addr = r_fill_addr;
        n_fill_end  = r_fill_end;
        n_pend_scr  = r_pend_scr;
        n_pend_data = r_pend_data;
        n_rd_ok     = r_rd_ok;
        wr_en       = 1'b0;
        wr_addr     = r_fill_addr;
        wr_data     = {r_attr, BLANK_CHAR};
        rd_en       = 1'b0;
        rd_addr     = f_phys(i_q.cmd.cell_addr, r_base);
        pop         = 1'b0;
        load_out    = 1'b0;
        adv_row     = 1'b0;

        unique case (r_state)
            S_INIT: begin
                // blanks at the reset attribute, whatever the register holds
                wr_en       = 1'b1;
                wr_data     = {RESET_ATTR, BLANK_CHAR};
                n_fill_addr = r_fill_addr + ADDR_W'(1);
                if (r_fill_addr == LAST_CELL) begin
                    n_fill_addr = '0;
                    n_state     = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q.valid) begin
                    pop         = 1'b1;
                    n_pend_scr  = 1'b0;
                    n_pend_data = '0;
                    n_state     = S_EMIT;
                    unique case (i_q.cmd.kind)
                        K_CHAR: begin
                            wr_en   = 1'b1;
                            wr_addr = f_phys(r_lin, r_base);
                            wr_data = {r_attr, i_q.cmd.char_code};
                            if (col_inc == COLS_C) begin
                                adv_row = 1'b1;
                            end else begin
                                n_col = col_inc[COL_W-1:0];
                                n_lin = r_lin + ADDR_W'(1);
                            end
                        end
                        K_NEWLINE: adv_row = 1'b1;
                        K_RETURN: begin
                            n_col = '0;
                            n_lin = row_start;
                        end
                        K_TAB: begin
                            if (tab_col >= COLS_C) begin
                                adv_row = 1'b1;
                            end else begin
                                n_col = tab_col[COL_W-1:0];
                                n_lin = row_start + ADDR_W'(tab_col);
                            end
                        end
                        K_BACKSPACE: begin
                            if (r_col != '0) begin
                                n_col = r_col - COL_W'(1);
                                n_lin = bs_lin;
                            end
                            wr_en   = 1'b1;
                            wr_addr = f_phys(bs_lin, r_base);
                        end
                        K_CLEAR: begin
                            n_row       = '0;
                            n_col       = '0;
                            n_lin       = '0;
                            n_base      = '0;
                            n_fill_addr = '0;
                            n_fill_end  = LAST_CELL;
                            n_state     = S_FILL;
                        end
                        K_READ: begin
                            rd_en   = i_q.cmd.read_ok;
                            n_rd_ok = i_q.cmd.read_ok;
                            n_state = S_READ;
                        end
                        default: ;
                    endcase
                    if (adv_row) begin
                        n_col = '0;
                        if (r_row == LAST_ROW) begin
                            // scroll: old top row becomes the new blank bottom row
                            n_lin       = BOTTOM_LIN;
                            n_base      = f_phys(ADDR_W'(COLUMNS), r_base);
                            n_fill_addr = r_base;
                            n_fill_end  = r_base + ADDR_W'(COLUMNS - 1);
                            n_pend_scr  = 1'b1;
                            n_state     = S_FILL;
                        end else begin
                            n_row = r_row + ROW_W'(1);
                            n_lin = row_start + ADDR_W'(COLUMNS);
                        end
                    end
                end
            end
            S_FILL: begin
                wr_en       = 1'b1;
                n_fill_addr = r_fill_addr + ADDR_W'(1);
                if (r_fill_addr == r_fill_end) begin
                    n_state = S_EMIT;
                end
            end
            S_READ: begin
                n_pend_data = r_rd_ok ? r_rd_data : 16'h0000;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Cell memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_row       <= '0;
            r_col       <= '0;
            r_lin       <= '0;
            r_base      <= '0;
            r_attr      <= RESET_ATTR;
            r_fill_addr <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_lin       <= n_lin;
            r_base      <= n_base;
            r_fill_addr <= n_fill_addr;
            if (i_cfg_we) begin
                r_attr <= i_cfg_wdata;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fill_end  <= n_fill_end;
        r_pend_scr  <= n_pend_scr;
        r_pend_data <= n_pend_data;
        r_rd_ok     <= n_rd_ok;
        if (load_out) begin
            r_out_row  <= row_ext[4:0];
            r_out_col  <= col_ext[6:0];
            r_out_pos  <= lin_ext[10:0];
            r_out_scr  <= r_pend_scr;
            r_out_data <= r_pend_data;
        end
    end

    assign o_ctrl.pop       = pop;
    assign o_ctrl.init_busy = (r_state == S_INIT);

    assign o_out_valid       = r_out_valid;
    assign o_cursor_line     = r_out_row;
    assign o_cursor_column   = r_out_col;
    assign o_cursor_position = r_out_pos;
    assign o_scrolled        = r_out_scr;
    assign o_cell_data       = r_out_data;

`ifndef SYNTHESIS
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= LAST_ROW)
        else $error("cursor row beyond last row");

    a_lin_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_lin) == (32'(r_row) * COLUMNS + 32'(r_col)))
        else $error("linear cursor out of step with row and column");

    a_base_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_base) < CELL_COUNT)
        else $error("row base outside the grid");

    a_scroll_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_scr) |-> (r_out_col == 7'd0))
        else $error("scroll reported with cursor off column 0");
`endif

endmodule
